[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the set partition walker RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define SPW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/spw_pkg.sv]
// ----------------------------------------------------------------------------
// spw_pkg
// Types, codes and helpers of the set partition walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spw_pkg;

  localparam int LBL_W   = 4;
  localparam int NUM_LBL = 16;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 15;
  localparam int KIND_W  = 3;

  // command codes
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ONE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SINGLE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MERGE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SPLIT   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CNT, S_DISP, S_ADV, S_ADVW, S_MSQ, S_MREL,
    S_SWALK, S_SAPP, S_CAN, S_SUM, S_DONE
  } spw_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  move_index;
  } spw_cmd_t;

  typedef struct packed {
    logic [31:0]      labels_low;
    logic [31:0]      labels_high;
    logic [4:0]       group_total;
    logic [6:0]       merge_total;
    logic [IDX_W-1:0] split_total;
    logic             wrapped;
    logic             rejected;
  } spw_res_t;

  // number of two-way splits of a group of the given size
  function automatic logic [IDX_W-1:0] splits_of(input logic [CNT_W-1:0] size);
    logic [15:0] v;
    v = (16'd1 << (size - 5'd1)) - 16'd1;
    return (size == 5'd0) ? '0 : v[IDX_W-1:0];
  endfunction

  // pairs of groups, g choose two
  function automatic logic [6:0] merge_tot(input logic [4:0] g);
    logic [9:0] p;
    p = 10'(g) * 10'(g - 5'd1);
    return p[7:1];
  endfunction

endpackage

[src/spw_hist.sv]
// ----------------------------------------------------------------------------
// spw_hist
// Group size histogram: one counter per label, all cleared in the same cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spw_hist (
  input  logic                     clk,
  input  logic                     clr,
  input  logic                     inc_en,
  input  logic [spw_pkg::LBL_W-1:0] inc_addr,
  input  logic [spw_pkg::LBL_W-1:0] rd_addr,
  output logic [spw_pkg::CNT_W-1:0] rd_cnt
);

  logic [spw_pkg::CNT_W-1:0] cnt_r [spw_pkg::NUM_LBL];

  // clear all counters or bump one counter
  always_ff @(posedge clk) begin
    if (clr) begin
      for (int i = 0; i < spw_pkg::NUM_LBL; i++) cnt_r[i] <= '0;
    end else if (inc_en) begin
      cnt_r[inc_addr] <= cnt_r[inc_addr] + 5'd1;
    end
  end

  assign rd_cnt = cnt_r[rd_addr];

endmodule

[src/spw_core.sv]
// ----------------------------------------------------------------------------
// spw_core
// Label store, sequencer and shared add/subtract unit of the walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spw_core #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  spw_pkg::spw_cmd_t cmd,
  input  logic [4:0]        n_elem,
  input  logic              cfg_clear,
  input  logic              out_free,
  output logic              idle,
  output logic              done,
  output spw_pkg::spw_res_t res
);

  localparam int JW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  spw_pkg::spw_state_t state_r, state_nxt;

  logic [spw_pkg::LBL_W-1:0]  labels_r [MAX_ELEMENTS];
  logic [spw_pkg::LBL_W-1:0]  labels_nxt [MAX_ELEMENTS];
  logic [spw_pkg::LBL_W-1:0]  map_r [spw_pkg::NUM_LBL];
  logic [spw_pkg::LBL_W-1:0]  map_nxt [spw_pkg::NUM_LBL];
  logic [spw_pkg::NUM_LBL-1:0] seen_r, seen_nxt;
  logic [JW-1:0]              j_r, j_nxt, k_r, k_nxt;
  logic [spw_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [spw_pkg::IDX_W-1:0]  t_r, t_nxt, acc_r, acc_nxt;
  logic [4:0]                 s_r, s_nxt, g_r, g_nxt, next_r, next_nxt;
  logic [spw_pkg::LBL_W-1:0]  gmax_r, gmax_nxt, pm_r, pm_nxt;
  logic post_r, post_nxt, found_r, found_nxt, first_r, first_nxt;
  logic wrapped_r, wrapped_nxt, rejected_r, rejected_nxt;

  logic [spw_pkg::LBL_W-1:0] lab_j;
  logic [4:0]                grp_total;
  logic                      last_j;
  logic [spw_pkg::CNT_W-1:0] hist_cnt;
  logic [spw_pkg::IDX_W-1:0] split_c;
  logic                      hist_clr, hist_inc;

  // shared add/subtract unit
  logic [15:0] alu_a, alu_b, alu_res;
  logic        alu_sub, alu_ge;

  assign lab_j     = labels_r[j_r];
  assign grp_total = {1'b0, gmax_r} + 5'd1;
  assign last_j    = (5'(j_r) == n_elem - 5'd1);
  assign split_c   = spw_pkg::splits_of(hist_cnt);
  assign alu_res   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_ge    = (alu_a >= alu_b);

  spw_hist u_hist (
    .clk      (clk),
    .clr      (hist_clr),
    .inc_en   (hist_inc),
    .inc_addr (lab_j),
    .rd_addr  (g_r[3:0]),
    .rd_cnt   (hist_cnt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spw_pkg::S_IDLE:  if (start) state_nxt = spw_pkg::S_CLR;
      spw_pkg::S_CLR:   state_nxt = spw_pkg::S_CNT;
      spw_pkg::S_CNT:
        if (last_j) state_nxt = post_r ? spw_pkg::S_SUM : spw_pkg::S_DISP;
      spw_pkg::S_DISP: begin
        priority case (kind_r)
          spw_pkg::KIND_ADVANCE: state_nxt = spw_pkg::S_ADV;
          spw_pkg::KIND_MERGE:
            state_nxt = (t_r >= 15'(spw_pkg::merge_tot(grp_total))) ?
                        spw_pkg::S_CLR : spw_pkg::S_MSQ;
          spw_pkg::KIND_SPLIT:   state_nxt = spw_pkg::S_SWALK;
          default:               state_nxt = spw_pkg::S_CLR;
        endcase
      end
      spw_pkg::S_ADV:   if (last_j) state_nxt = spw_pkg::S_ADVW;
      spw_pkg::S_ADVW:  state_nxt = spw_pkg::S_CLR;
      spw_pkg::S_MSQ:   if (!alu_ge) state_nxt = spw_pkg::S_MREL;
      spw_pkg::S_MREL:  state_nxt = spw_pkg::S_CAN;
      spw_pkg::S_SWALK: begin
        if (g_r >= grp_total)  state_nxt = spw_pkg::S_CLR;
        else if (!alu_ge)      state_nxt = spw_pkg::S_SAPP;
      end
      spw_pkg::S_SAPP:  if (last_j) state_nxt = spw_pkg::S_CAN;
      spw_pkg::S_CAN:   if (last_j) state_nxt = spw_pkg::S_CLR;
      spw_pkg::S_SUM:   if (g_r == 5'd15) state_nxt = spw_pkg::S_DONE;
      spw_pkg::S_DONE:  if (out_free) state_nxt = spw_pkg::S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    labels_nxt   = labels_r;
    map_nxt      = map_r;
    seen_nxt     = seen_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    kind_nxt     = kind_r;
    t_nxt        = t_r;
    acc_nxt      = acc_r;
    s_nxt        = s_r;
    g_nxt        = g_r;
    next_nxt     = next_r;
    gmax_nxt     = gmax_r;
    pm_nxt       = pm_r;
    post_nxt     = post_r;
    found_nxt    = found_r;
    first_nxt    = first_r;
    wrapped_nxt  = wrapped_r;
    rejected_nxt = rejected_r;
    hist_clr     = 1'b0;
    hist_inc     = 1'b0;
    alu_a        = {1'b0, t_r};
    alu_b        = 16'(s_r);
    alu_sub      = 1'b1;

    unique case (state_r)
      spw_pkg::S_IDLE: begin
        if (cfg_clear) begin
          for (int i = 0; i < MAX_ELEMENTS; i++) labels_nxt[i] = '0;
        end
        if (start) begin
          kind_nxt     = cmd.kind;
          t_nxt        = cmd.move_index;
          post_nxt     = 1'b0;
          wrapped_nxt  = 1'b0;
          rejected_nxt = 1'b0;
        end
      end
      spw_pkg::S_CLR: begin
        hist_clr = 1'b1;
        gmax_nxt = '0;
        j_nxt    = '0;
        g_nxt    = '0;
        acc_nxt  = '0;
      end
      spw_pkg::S_CNT: begin
        hist_inc = 1'b1;
        if (lab_j > gmax_r) gmax_nxt = lab_j;
        j_nxt = last_j ? '0 : j_r + 1'b1;
      end
      spw_pkg::S_DISP: begin
        s_nxt     = 5'd1;
        g_nxt     = '0;
        j_nxt     = '0;
        found_nxt = 1'b0;
        first_nxt = 1'b1;
        next_nxt  = '0;
        seen_nxt  = '0;
        post_nxt  = 1'b1;
        priority case (kind_r)
          spw_pkg::KIND_ONE: begin
            for (int i = 0; i < MAX_ELEMENTS; i++) labels_nxt[i] = '0;
          end
          spw_pkg::KIND_SINGLE: begin
            for (int i = 0; i < MAX_ELEMENTS; i++)
              if (5'(i) < n_elem) labels_nxt[i] = 4'(i);
          end
          spw_pkg::KIND_MERGE:
            if (t_r >= 15'(spw_pkg::merge_tot(grp_total))) rejected_nxt = 1'b1;
          default: ;
        endcase
      end
      spw_pkg::S_ADV: begin
        // running prefix maximum, remember the last element that can grow
        if (j_r == '0) begin
          pm_nxt = lab_j;
        end else begin
          if (lab_j <= pm_r) begin
            found_nxt = 1'b1;
            k_nxt     = j_r;
          end
          if (lab_j > pm_r) pm_nxt = lab_j;
        end
        j_nxt = last_j ? '0 : j_r + 1'b1;
      end
      spw_pkg::S_ADVW: begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
          if (!found_r || JW'(i) > k_r) labels_nxt[i] = '0;
        end
        if (found_r) labels_nxt[k_r] = labels_r[k_r] + 4'd1;
        else wrapped_nxt = 1'b1;
      end
      spw_pkg::S_MSQ: begin
        // peel off triangular rows: t -= s while t >= s
        if (alu_ge) begin
          t_nxt = alu_res[spw_pkg::IDX_W-1:0];
          s_nxt = s_r + 5'd1;
        end
      end
      spw_pkg::S_MREL: begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
          if (5'(i) < n_elem && labels_r[i] == s_r[3:0]) labels_nxt[i] = t_r[3:0];
      end
      spw_pkg::S_SWALK: begin
        alu_b = {1'b0, split_c};
        if (g_r >= grp_total) begin
          rejected_nxt = 1'b1;
        end else if (alu_ge) begin
          t_nxt = alu_res[spw_pkg::IDX_W-1:0];
          g_nxt = g_r + 5'd1;
        end
      end
      spw_pkg::S_SAPP: begin
        if (lab_j == g_r[3:0]) begin
          if (first_r) begin
            first_nxt = 1'b0;
          end else begin
            if (!t_r[0]) labels_nxt[j_r] = grp_total[3:0];
            t_nxt = t_r >> 1;
          end
        end
        j_nxt = last_j ? '0 : j_r + 1'b1;
      end
      spw_pkg::S_CAN: begin
        // renumber labels in order of first appearance
        if (!seen_r[lab_j]) begin
          seen_nxt[lab_j] = 1'b1;
          map_nxt[lab_j]  = next_r[3:0];
          labels_nxt[j_r] = next_r[3:0];
          next_nxt        = next_r + 5'd1;
        end else begin
          labels_nxt[j_r] = map_r[lab_j];
        end
        j_nxt = last_j ? '0 : j_r + 1'b1;
      end
      spw_pkg::S_SUM: begin
        alu_a   = {1'b0, acc_r};
        alu_b   = {1'b0, split_c};
        alu_sub = 1'b0;
        acc_nxt = alu_res[spw_pkg::IDX_W-1:0];
        g_nxt   = g_r + 5'd1;
      end
      spw_pkg::S_DONE: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spw_pkg::S_IDLE;
      post_r  <= 1'b0;
      j_r     <= '0;
      g_r     <= '0;
      for (int i = 0; i < MAX_ELEMENTS; i++) labels_r[i] <= '0;
    end else begin
      state_r  <= state_nxt;
      post_r   <= post_nxt;
      j_r      <= j_nxt;
      g_r      <= g_nxt;
      labels_r <= labels_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    map_r      <= map_nxt;
    seen_r     <= seen_nxt;
    k_r        <= k_nxt;
    kind_r     <= kind_nxt;
    t_r        <= t_nxt;
    acc_r      <= acc_nxt;
    s_r        <= s_nxt;
    next_r     <= next_nxt;
    gmax_r     <= gmax_nxt;
    pm_r       <= pm_nxt;
    found_r    <= found_nxt;
    first_r    <= first_nxt;
    wrapped_r  <= wrapped_nxt;
    rejected_r <= rejected_nxt;
  end

  // result packing, elements past the count read as zero
  always_comb begin
    res = '0;
    for (int i = 0; i < MAX_ELEMENTS && i < 16; i++) begin
      if (5'(i) < n_elem) begin
        if (i < 8) res.labels_low[4*i +: 4] = labels_r[i];
        else res.labels_high[4*(i-8) +: 4] = labels_r[i];
      end
    end
    res.group_total = grp_total;
    res.merge_total = spw_pkg::merge_tot(grp_total);
    res.split_total = acc_r;
    res.wrapped     = wrapped_r;
    res.rejected    = rejected_r;
  end

  assign idle = (state_r == spw_pkg::S_IDLE);
  assign done = (state_r == spw_pkg::S_DONE);

endmodule

[src/set_partition_walker.sv]
// ----------------------------------------------------------------------------
// set_partition_walker
// Set partition walker: steps, resets, merges and splits a partition held as
// a restricted growth string of group labels
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | kind, move_index
//   out_    | output    | out_valid/out_ready | labels, totals, wrapped, rejected
//   cfg_    | input     | APB psel/penable    | element_count
//
// A command runs through the element-serial passes of the sequencer (count,
// command, renumber where the command needs it, count) and then the
// sixteen-group split sum through the shared add/subtract unit.
// in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; the sequencer holds in its
// done state while that register is still full and out_ready is low.
// Reset is synchronous, active low; the partition resets to one group.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module set_partition_walker #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [14:0] in_move_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_labels_low,
  output logic [31:0] out_labels_high,
  output logic [4:0]  out_group_total,
  output logic [6:0]  out_merge_total,
  output logic [14:0] out_split_total,
  output logic        out_wrapped,
  output logic        out_rejected,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [4:0]        elem_cnt_r, elem_cnt_nxt;
  logic [4:0]        n_elem;
  logic              cfg_wr;
  logic              core_idle, core_done, out_free, start;
  logic              out_valid_r, out_valid_nxt;
  spw_pkg::spw_res_t res, out_r;
  spw_pkg::spw_cmd_t cmd;

  // configuration register
  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign elem_cnt_nxt = cfg_wr ? cfg_pwdata[4:0] : elem_cnt_r;
  assign cfg_prdata   = cfg_paddr[2] ? 32'd0 : {27'd0, elem_cnt_r};

  // element count clamped into range
  always_comb begin
    priority if (elem_cnt_r == 5'd0)                n_elem = 5'd1;
    else if (elem_cnt_r > 5'(MAX_ELEMENTS))         n_elem = 5'(MAX_ELEMENTS);
    else                                            n_elem = elem_cnt_r;
  end

  assign in_ready = core_idle;
  assign start    = in_valid && in_ready;
  assign cmd      = '{kind: in_kind, move_index: in_move_index};
  assign out_free = !out_valid_r || out_ready;

  spw_core #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .n_elem    (n_elem),
    .cfg_clear (cfg_wr),
    .out_free  (out_free),
    .idle      (core_idle),
    .done      (core_done),
    .res       (res)
  );

  // output register
  assign out_valid_nxt = (core_done && out_free) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r  <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      elem_cnt_r  <= elem_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done && out_free) out_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_labels_low  = out_r.labels_low;
  assign out_labels_high = out_r.labels_high;
  assign out_group_total = out_r.group_total;
  assign out_merge_total = out_r.merge_total;
  assign out_split_total = out_r.split_total;
  assign out_wrapped     = out_r.wrapped;
  assign out_rejected    = out_r.rejected;

  // checks
  `SPW_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)
  `SPW_ASSERT_IMP(a_flags_exclusive, clk, rst_n, out_valid, !(out_wrapped && out_rejected))
  `SPW_ASSERT_IMP(a_group_range, clk, rst_n, out_valid,
                  out_group_total != 5'd0 && out_group_total <= 5'(MAX_ELEMENTS))
  `SPW_ASSERT_IMP(a_one_group_no_merge, clk, rst_n, out_valid && out_group_total == 5'd1,
                  out_merge_total == 7'd0)

endmodule
